/* design/mmix_pkg.sv */
// ============================================================================
// Motor mixer package
// Shared widths, register indexes and the structs that run between the
// configuration block, the mixing pipeline and the limiting pipeline.
// ============================================================================
package mmix_pkg;

    // Motor lanes carried by the datapath, and how many of them are in use.
    localparam int NUM_MOTORS  = 4;
    localparam int MOTOR_COUNT = 4;

    // Field widths.
    localparam int DATA_W = 16;
    localparam int CNT_W  = 16;

    // A coefficient times a command, and the sum of six such products.
    localparam int PROD_W = 2 * DATA_W;
    localparam int SUM_W  = PROD_W + 2;

    // The mixed sum is divided by 256, truncating toward zero.
    localparam int MIX_SHIFT = 8;

    // Motor value after the divide plus thrust, and after the limit shift.
    localparam int MOT_W = SUM_W - MIX_SHIFT + 2;
    localparam int SH_W  = MOT_W + 2;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = NUM_MOTORS * DATA_W;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_ROLL_COEFS    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PITCH_COEFS   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_YAW_COEFS     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TRIM_ROLL     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TRIM_PITCH    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TRIM_YAW      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_MOTOR_FLOOR   = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_MOTOR_CEILING = 3'd7;

    // Settings used by the mixing pipeline: packed coefficients, motor 0 in
    // the low lane, and the per-motor trim terms.
    typedef struct packed {
        logic [CFG_DATA_W-1:0]       roll_coefs;
        logic [CFG_DATA_W-1:0]       pitch_coefs;
        logic [CFG_DATA_W-1:0]       yaw_coefs;
        logic [NUM_MOTORS*SUM_W-1:0] trim;
    } mix_cfg_t;

    // Settings used by the limiting pipeline.
    typedef struct packed {
        logic signed [DATA_W-1:0] motor_floor;
        logic signed [DATA_W-1:0] motor_ceiling;
    } lim_cfg_t;

    // Mixed motor values between the two pipelines, motor 0 in the low lane.
    typedef logic [NUM_MOTORS*MOT_W-1:0] motor_vec_t;

endpackage

/* design/multirotor_motor_mixer.sv */
// ============================================================================
// Multirotor motor mixer
// Mixes thrust, roll, pitch and yaw commands into four motor commands,
// shifts them into the floor-to-ceiling range and clamps them.
// ============================================================================
// Pipeline: six register stages.
// Throughput: one item per cycle while out_stall is low; each of the six pipeline
// stages holds one item and a stage refills as soon as its item moves on.
// Reset: all valid bits and the failure counter clear, coefficients and trims
// clear, the floor resets to 0 and the ceiling to 32767.
module multirotor_motor_mixer (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [mmix_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mmix_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               armed,
    input  logic signed [mmix_pkg::DATA_W-1:0] thrust,
    input  logic signed [mmix_pkg::DATA_W-1:0] roll,
    input  logic signed [mmix_pkg::DATA_W-1:0] pitch,
    input  logic signed [mmix_pkg::DATA_W-1:0] yaw,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [mmix_pkg::DATA_W-1:0] motor_zero,
    output logic signed [mmix_pkg::DATA_W-1:0] motor_one,
    output logic signed [mmix_pkg::DATA_W-1:0] motor_two,
    output logic signed [mmix_pkg::DATA_W-1:0] motor_three,
    output logic [mmix_pkg::CNT_W-1:0]         failure_count
);

    mmix_pkg::mix_cfg_t     mix_cfg;
    mmix_pkg::lim_cfg_t     lim_cfg;
    logic                   mix_valid;
    logic                   mix_stall;
    logic                   mix_on;
    mmix_pkg::motor_vec_t   mix_motors;

    // Configuration registers.
    mmix_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mix_cfg   (mix_cfg),
        .lim_cfg   (lim_cfg)
    );

    // Mixing stages.
    mmix_mix u_mix (
        .clk        (clk),
        .rst_n      (rst_n),
        .mix_cfg    (mix_cfg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .armed      (armed),
        .thrust     (thrust),
        .roll       (roll),
        .pitch      (pitch),
        .yaw        (yaw),
        .out_valid  (mix_valid),
        .out_stall  (mix_stall),
        .out_on     (mix_on),
        .out_motors (mix_motors)
    );

    // Limiting stages.
    mmix_limit u_limit (
        .clk           (clk),
        .rst_n         (rst_n),
        .lim_cfg       (lim_cfg),
        .in_valid      (mix_valid),
        .in_stall      (mix_stall),
        .in_on         (mix_on),
        .in_motors     (mix_motors),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .motor_zero    (motor_zero),
        .motor_one     (motor_one),
        .motor_two     (motor_two),
        .motor_three   (motor_three),
        .failure_count (failure_count)
    );

endmodule

/* design/mmix_cfg.sv */
// ============================================================================
// Motor mixer configuration registers
// Holds the mixing coefficients, trims and limits, and keeps a registered
// copy of each motor's trim term so the pipeline never multiplies the trims.
// ============================================================================
module mmix_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [mmix_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mmix_pkg::CFG_DATA_W-1:0]   cfg_data,
    output mmix_pkg::mix_cfg_t                mix_cfg,
    output mmix_pkg::lim_cfg_t                lim_cfg
);

    logic [mmix_pkg::CFG_DATA_W-1:0]               roll_coefs_reg;
    logic [mmix_pkg::CFG_DATA_W-1:0]               pitch_coefs_reg;
    logic [mmix_pkg::CFG_DATA_W-1:0]               yaw_coefs_reg;
    logic signed [mmix_pkg::DATA_W-1:0]            trim_roll_reg;
    logic signed [mmix_pkg::DATA_W-1:0]            trim_pitch_reg;
    logic signed [mmix_pkg::DATA_W-1:0]            trim_yaw_reg;
    logic signed [mmix_pkg::DATA_W-1:0]            motor_floor_reg;
    logic signed [mmix_pkg::DATA_W-1:0]            motor_ceiling_reg;
    logic [mmix_pkg::NUM_MOTORS*mmix_pkg::SUM_W-1:0] trim_reg;
    logic [mmix_pkg::NUM_MOTORS*mmix_pkg::SUM_W-1:0] trim_next;

    // Register writes; the user must not send an item in the same cycle as a write (not enforced here).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_coefs_reg    <= '0;
            pitch_coefs_reg   <= '0;
            yaw_coefs_reg     <= '0;
            trim_roll_reg     <= '0;
            trim_pitch_reg    <= '0;
            trim_yaw_reg      <= '0;
            motor_floor_reg   <= '0;
            motor_ceiling_reg <= 16'sh7FFF;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mmix_pkg::REG_ROLL_COEFS:    roll_coefs_reg    <= cfg_data;
                mmix_pkg::REG_PITCH_COEFS:   pitch_coefs_reg   <= cfg_data;
                mmix_pkg::REG_YAW_COEFS:     yaw_coefs_reg     <= cfg_data;
                mmix_pkg::REG_TRIM_ROLL:     trim_roll_reg     <= cfg_data[mmix_pkg::DATA_W-1:0];
                mmix_pkg::REG_TRIM_PITCH:    trim_pitch_reg    <= cfg_data[mmix_pkg::DATA_W-1:0];
                mmix_pkg::REG_TRIM_YAW:      trim_yaw_reg      <= cfg_data[mmix_pkg::DATA_W-1:0];
                mmix_pkg::REG_MOTOR_FLOOR:   motor_floor_reg   <= cfg_data[mmix_pkg::DATA_W-1:0];
                mmix_pkg::REG_MOTOR_CEILING: motor_ceiling_reg <= cfg_data[mmix_pkg::DATA_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Per-motor trim: each coefficient times its trim, summed.
    always_comb
    begin
        logic signed [mmix_pkg::DATA_W-1:0] rc;
        logic signed [mmix_pkg::DATA_W-1:0] pc;
        logic signed [mmix_pkg::DATA_W-1:0] yc;
        logic signed [mmix_pkg::PROD_W-1:0] pr;
        logic signed [mmix_pkg::PROD_W-1:0] pp;
        logic signed [mmix_pkg::PROD_W-1:0] py;
        trim_next = '0;
        for (int i = 0; i < mmix_pkg::NUM_MOTORS; i++)
        begin
            rc = $signed(roll_coefs_reg[i*mmix_pkg::DATA_W +: mmix_pkg::DATA_W]);
            pc = $signed(pitch_coefs_reg[i*mmix_pkg::DATA_W +: mmix_pkg::DATA_W]);
            yc = $signed(yaw_coefs_reg[i*mmix_pkg::DATA_W +: mmix_pkg::DATA_W]);
            pr = rc * trim_roll_reg;
            pp = pc * trim_pitch_reg;
            py = yc * trim_yaw_reg;
            trim_next[i*mmix_pkg::SUM_W +: mmix_pkg::SUM_W] =
                mmix_pkg::SUM_W'(pr) + mmix_pkg::SUM_W'(pp) + mmix_pkg::SUM_W'(py);
        end
    end

    // The trim copy is registered and follows the registers in the cycle after; it is first used
    // by the second pipeline stage, so a fresh item always sees it settled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trim_reg <= '0;
        end
        else
        begin
            trim_reg <= trim_next;
        end
    end

    assign mix_cfg.roll_coefs    = roll_coefs_reg;
    assign mix_cfg.pitch_coefs   = pitch_coefs_reg;
    assign mix_cfg.yaw_coefs     = yaw_coefs_reg;
    assign mix_cfg.trim          = trim_reg;
    assign lim_cfg.motor_floor   = motor_floor_reg;
    assign lim_cfg.motor_ceiling = motor_ceiling_reg;

endmodule

/* design/mmix_mix.sv */
// ============================================================================
// Motor mixer mixing pipeline
// Three stages: coefficient products, sum with trim, then divide by 256
// toward zero and add thrust.
// ============================================================================
module mmix_mix (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mmix_pkg::mix_cfg_t                mix_cfg,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              armed,
    input  logic signed [mmix_pkg::DATA_W-1:0] thrust,
    input  logic signed [mmix_pkg::DATA_W-1:0] roll,
    input  logic signed [mmix_pkg::DATA_W-1:0] pitch,
    input  logic signed [mmix_pkg::DATA_W-1:0] yaw,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              out_on,
    output mmix_pkg::motor_vec_t              out_motors
);

    logic                                 v1_reg;
    logic                                 v2_reg;
    logic                                 v3_reg;
    logic                                 ld1;
    logic                                 ld2;
    logic                                 ld3;
    logic                                 on1_reg;
    logic                                 on2_reg;
    logic                                 on3_reg;
    logic signed [mmix_pkg::DATA_W-1:0]   thrust1_reg;
    logic signed [mmix_pkg::DATA_W-1:0]   thrust2_reg;
    logic signed [mmix_pkg::PROD_W-1:0]   prod_roll_reg  [mmix_pkg::NUM_MOTORS];
    logic signed [mmix_pkg::PROD_W-1:0]   prod_pitch_reg [mmix_pkg::NUM_MOTORS];
    logic signed [mmix_pkg::PROD_W-1:0]   prod_yaw_reg   [mmix_pkg::NUM_MOTORS];
    logic signed [mmix_pkg::SUM_W-1:0]    sum_reg        [mmix_pkg::NUM_MOTORS];
    logic signed [mmix_pkg::MOT_W-1:0]    motor_next     [mmix_pkg::NUM_MOTORS];
    logic signed [mmix_pkg::MOT_W-1:0]    motor_reg      [mmix_pkg::NUM_MOTORS];

    // A stage loads when it is empty or its item moves on.
    assign ld3      = !v3_reg || !out_stall;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign in_stall = !ld1;

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                v1_reg <= in_valid;
            end
            if (ld2)
            begin
                v2_reg <= v1_reg;
            end
            if (ld3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Stage 1: one product per coefficient and command.
    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            on1_reg     <= armed;
            thrust1_reg <= thrust;
            for (int i = 0; i < mmix_pkg::NUM_MOTORS; i++)
            begin
                prod_roll_reg[i]  <= $signed(mix_cfg.roll_coefs[i*mmix_pkg::DATA_W +:
                                                                mmix_pkg::DATA_W]) * roll;
                prod_pitch_reg[i] <= $signed(mix_cfg.pitch_coefs[i*mmix_pkg::DATA_W +:
                                                                 mmix_pkg::DATA_W]) * pitch;
                prod_yaw_reg[i]   <= $signed(mix_cfg.yaw_coefs[i*mmix_pkg::DATA_W +:
                                                               mmix_pkg::DATA_W]) * yaw;
            end
        end
    end

    // Stage 2: products plus the motor trim.
    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            on2_reg     <= on1_reg;
            thrust2_reg <= thrust1_reg;
            for (int i = 0; i < mmix_pkg::NUM_MOTORS; i++)
            begin
                sum_reg[i] <= mmix_pkg::SUM_W'(prod_roll_reg[i])
                            + mmix_pkg::SUM_W'(prod_pitch_reg[i])
                            + mmix_pkg::SUM_W'(prod_yaw_reg[i])
                            + $signed(mix_cfg.trim[i*mmix_pkg::SUM_W +: mmix_pkg::SUM_W]);
            end
        end
    end

    // Stage 3: arithmetic shift rounds down, so a negative sum with a nonzero
    // remainder is moved up by one to truncate toward zero.
    always_comb
    begin
        logic signed [mmix_pkg::SUM_W-1:0] quot;
        for (int i = 0; i < mmix_pkg::NUM_MOTORS; i++)
        begin
            quot = sum_reg[i] >>> mmix_pkg::MIX_SHIFT;
            if (sum_reg[i][mmix_pkg::SUM_W-1] && (sum_reg[i][mmix_pkg::MIX_SHIFT-1:0] != '0))
            begin
                quot = quot + mmix_pkg::SUM_W'(1);
            end
            motor_next[i] = mmix_pkg::MOT_W'(quot) + mmix_pkg::MOT_W'(thrust2_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            on3_reg <= on2_reg;
            for (int i = 0; i < mmix_pkg::NUM_MOTORS; i++)
            begin
                motor_reg[i] <= motor_next[i];
            end
        end
    end

    assign out_valid = v3_reg;
    assign out_on    = on3_reg;

    always_comb
    begin
        for (int i = 0; i < mmix_pkg::NUM_MOTORS; i++)
        begin
            out_motors[i*mmix_pkg::MOT_W +: mmix_pkg::MOT_W] = motor_reg[i];
        end
    end

endmodule

/* design/mmix_limit.sv */
// ============================================================================
// Motor mixer limiting pipeline
// Three stages: minimum and maximum search, shift into range with the
// failure count, then clamp to floor and ceiling.
// ============================================================================
module mmix_limit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mmix_pkg::lim_cfg_t                 lim_cfg,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               in_on,
    input  mmix_pkg::motor_vec_t               in_motors,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [mmix_pkg::DATA_W-1:0] motor_zero,
    output logic signed [mmix_pkg::DATA_W-1:0] motor_one,
    output logic signed [mmix_pkg::DATA_W-1:0] motor_two,
    output logic signed [mmix_pkg::DATA_W-1:0] motor_three,
    output logic [mmix_pkg::CNT_W-1:0]         failure_count
);

    logic                                 v4_reg;
    logic                                 v5_reg;
    logic                                 v6_reg;
    logic                                 ld4;
    logic                                 ld5;
    logic                                 ld6;
    logic signed [mmix_pkg::DATA_W-1:0]   lo;
    logic signed [mmix_pkg::DATA_W-1:0]   hi;
    logic signed [mmix_pkg::MOT_W-1:0]    motor_in [mmix_pkg::NUM_MOTORS];
    logic signed [mmix_pkg::MOT_W-1:0]    min_next;
    logic signed [mmix_pkg::MOT_W-1:0]    max_next;
    logic                                 on4_reg;
    logic                                 below4_reg;
    logic                                 above4_reg;
    logic signed [mmix_pkg::MOT_W-1:0]    min4_reg;
    logic signed [mmix_pkg::MOT_W-1:0]    max4_reg;
    logic signed [mmix_pkg::MOT_W-1:0]    motor4_reg [mmix_pkg::NUM_MOTORS];
    logic signed [mmix_pkg::SH_W-1:0]     raise;
    logic signed [mmix_pkg::SH_W-1:0]     lower;
    logic                                 fail;
    logic [mmix_pkg::CNT_W-1:0]           failure_counter_reg;
    logic [mmix_pkg::CNT_W-1:0]           failure_counter_next;
    logic                                 on5_reg;
    logic [mmix_pkg::CNT_W-1:0]           count5_reg;
    logic signed [mmix_pkg::SH_W-1:0]     motor5_reg [mmix_pkg::NUM_MOTORS];
    logic signed [mmix_pkg::DATA_W-1:0]   clamp_next [mmix_pkg::NUM_MOTORS];
    logic signed [mmix_pkg::DATA_W-1:0]   motor6_reg [mmix_pkg::NUM_MOTORS];
    logic [mmix_pkg::CNT_W-1:0]           count6_reg;

    assign lo = lim_cfg.motor_floor;
    assign hi = lim_cfg.motor_ceiling;

    // A stage loads when it is empty or its item moves on.
    assign ld6      = !v6_reg || !out_stall;
    assign ld5      = !v5_reg || ld6;
    assign ld4      = !v4_reg || ld5;
    assign in_stall = !ld4;

    // Valid bits and the failure counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg              <= 1'b0;
            v5_reg              <= 1'b0;
            v6_reg              <= 1'b0;
            failure_counter_reg <= '0;
        end
        else
        begin
            if (ld4)
            begin
                v4_reg <= in_valid;
            end
            if (ld5)
            begin
                v5_reg <= v4_reg;
                if (v4_reg)
                begin
                    failure_counter_reg <= failure_counter_next;
                end
            end
            if (ld6)
            begin
                v6_reg <= v5_reg;
            end
        end
    end

    // Stage 4: smallest and largest value over the motors in use.
    always_comb
    begin
        for (int i = 0; i < mmix_pkg::NUM_MOTORS; i++)
        begin
            motor_in[i] = $signed(in_motors[i*mmix_pkg::MOT_W +: mmix_pkg::MOT_W]);
        end
        min_next = motor_in[0];
        max_next = motor_in[0];
        for (int i = 1; i < mmix_pkg::MOTOR_COUNT; i++)
        begin
            if (motor_in[i] < min_next)
            begin
                min_next = motor_in[i];
            end
            if (motor_in[i] > max_next)
            begin
                max_next = motor_in[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld4)
        begin
            on4_reg    <= in_on;
            min4_reg   <= min_next;
            max4_reg   <= max_next;
            below4_reg <= min_next < mmix_pkg::MOT_W'(lo);
            above4_reg <= max_next > mmix_pkg::MOT_W'(hi);
            for (int i = 0; i < mmix_pkg::NUM_MOTORS; i++)
            begin
                motor4_reg[i] <= motor_in[i];
            end
        end
    end

    // Stage 5: raise by the shortfall and lower by the original excess.
    assign raise = below4_reg ? (mmix_pkg::SH_W'(lo) - mmix_pkg::SH_W'(min4_reg))
                              : '0;
    assign lower = above4_reg ? (mmix_pkg::SH_W'(max4_reg) - mmix_pkg::SH_W'(hi))
                              : '0;
    assign fail  = on4_reg && below4_reg && above4_reg;
    assign failure_counter_next = failure_counter_reg + mmix_pkg::CNT_W'(fail);

    always_ff @(posedge clk)
    begin
        if (ld5)
        begin
            on5_reg    <= on4_reg;
            count5_reg <= failure_counter_next;
            for (int i = 0; i < mmix_pkg::NUM_MOTORS; i++)
            begin
                motor5_reg[i] <= mmix_pkg::SH_W'(motor4_reg[i]) + raise - lower;
            end
        end
    end

    // Stage 6: the ceiling is tested first; motors off or unused give zero.
    always_comb
    begin
        for (int i = 0; i < mmix_pkg::NUM_MOTORS; i++)
        begin
            if (!on5_reg || (i >= mmix_pkg::MOTOR_COUNT))
            begin
                clamp_next[i] = '0;
            end
            else if (motor5_reg[i] > mmix_pkg::SH_W'(hi))
            begin
                clamp_next[i] = hi;
            end
            else if (motor5_reg[i] < mmix_pkg::SH_W'(lo))
            begin
                clamp_next[i] = lo;
            end
            else
            begin
                clamp_next[i] = motor5_reg[i][mmix_pkg::DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld6)
        begin
            count6_reg <= count5_reg;
            for (int i = 0; i < mmix_pkg::NUM_MOTORS; i++)
            begin
                motor6_reg[i] <= clamp_next[i];
            end
        end
    end

    assign out_valid     = v6_reg;
    assign motor_zero    = motor6_reg[0];
    assign motor_one     = motor6_reg[1];
    assign motor_two     = motor6_reg[2];
    assign motor_three   = motor6_reg[3];
    assign failure_count = count6_reg;

endmodule
